/* hw/rtl/psm_pkg.sv */
// ----------------------------------------------------------------------------
// psm_pkg
// Shared types, codes and constant tables of the polyphonic sine mixer.
// ----------------------------------------------------------------------------
package psm_pkg;

  localparam int OPCODE_W  = 2;
  localparam int VOICE_W   = 4;
  localparam int IN_DATA_W = 8;
  localparam int SAMPLE_W  = 32;
  localparam int FADE_W    = 16;
  localparam int VOLUME_W  = 28;
  localparam int SINE_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int FRAC_SHIFT = 15;

  localparam logic [FADE_W-1:0]   FADE_RESET = 16'd65503;
  localparam logic [VOLUME_W-1:0] BASE_RESET = 28'd165191049;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TICK    = 2'd0,
    OP_PRESS   = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE = 2'd0,
    REG_BASE = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic press;
    logic release_key;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_full;
  } status_t;

  // Equal-tempered steps from C4 upward at 48 kHz, 32-bit phase.
  localparam logic [31:0] STEP32 [16] = '{
    32'd23409859, 32'd24801882, 32'd26276679, 32'd27839171,
    32'd29494575, 32'd31248413, 32'd33106541, 32'd35075158,
    32'd37160835, 32'd39370534, 32'd41711627, 32'd44191930,
    32'd46819719, 32'd49603764, 32'd52553357, 32'd55678342
  };

  // Shift-subtract quotient, evaluated only while building the table.
  function automatic longint unsigned table_quot(longint unsigned num,
                                                 longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine, Q30 Taylor series with truncating products.
  function automatic logic [SINE_W-1:0] quarter_sine(longint unsigned i, int abits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (i * 64'd13493037705) >> (abits + 1);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      term = table_quot((term * x2) >> 30,
                        64'((2 * k) * (2 * k + 1)));
      if ((k & 1) == 1) begin
        sum = sum - longint'(term);
      end else begin
        sum = sum + longint'(term);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    r = (longint'(sum) * 64'd32767 + 64'd536870912) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return r[SINE_W-1:0];
  endfunction

  // Full-wave table entry built from mirrored and negated quarters.
  function automatic logic signed [SINE_W-1:0] sine_entry(int i, int abits);
    int q;
    int seg;
    int off;
    logic signed [SINE_W-1:0] v;
    q   = 1 << (abits - 2);
    seg = i >> (abits - 2);
    off = i & (q - 1);
    if (seg == 0 || seg == 2) begin
      v = quarter_sine(longint'(off), abits);
    end else begin
      v = quarter_sine(longint'(q - off), abits);
    end
    return (seg >= 2) ? -v : v;
  endfunction

endpackage

/* hw/rtl/polyphonic_sine_mixer_with_release_fade.sv */
// ----------------------------------------------------------------------------
// polyphonic_sine_mixer_with_release_fade
// Multi-voice sine mixer with key press/release and per-tick release fade.
//
//   Channel  Direction  Payload
//   in_      slave      tdata[1:0] opcode, tdata[5:2] voice_index
//   out_     master     tdata[31:0] mixed_sample, one per tick
//   cfg_     write      index 0 fade_factor, index 1 base_volume
//
// A tick runs through the accepting cycle, one voice per cycle through the
// multiply-accumulate lane, a drain of the two pipeline stages and the idle
// check, then the output load.
// Press, release and no-op items are taken in the idle state and leave it idle.
// Reset clears all voices and restores the register defaults at once.
// A waiting result stalls only the end of the next tick, not new items.
// ----------------------------------------------------------------------------
module polyphonic_sine_mixer_with_release_fade #(
  parameter int VOICE_COUNT    = 13,
  parameter int SINE_ADDR_BITS = 10,
  parameter int PHASE_BITS     = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [psm_pkg::IN_DATA_W-1:0]        in_tdata,   // opcode, voice_index
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [psm_pkg::SAMPLE_W-1:0]         out_tdata,  // mixed_sample
  input  logic                                 cfg_wr_en,
  input  logic [psm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [psm_pkg::VOLUME_W-1:0]         cfg_data
);
  import psm_pkg::*;

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  cmd_t              cmd;
  status_t           sts;
  logic [VIDX_W-1:0] issue_idx;
  opcode_t           opcode;
  logic [VOICE_W-1:0] voice_index;

  assign opcode      = opcode_t'(in_tdata[OPCODE_W-1:0]);
  assign voice_index = in_tdata[OPCODE_W +: VOICE_W];

  psm_ctrl #(
    .VOICE_COUNT (VOICE_COUNT),
    .VIDX_W      (VIDX_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .opcode    (opcode),
    .sts       (sts),
    .cmd       (cmd),
    .issue_idx (issue_idx)
  );

  psm_datapath #(
    .VOICE_COUNT    (VOICE_COUNT),
    .SINE_ADDR_BITS (SINE_ADDR_BITS),
    .PHASE_BITS     (PHASE_BITS),
    .VIDX_W         (VIDX_W)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .issue_idx  (issue_idx),
    .key_voice  (voice_index),
    .sts        (sts),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

/* hw/rtl/psm_ctrl.sv */
// ----------------------------------------------------------------------------
// psm_ctrl
// Controller: sequences ticks over the voices and key events.
// ----------------------------------------------------------------------------
module psm_ctrl #(
  parameter int VOICE_COUNT = 13,
  parameter int VIDX_W      = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  input  psm_pkg::opcode_t         opcode,
  input  psm_pkg::status_t         sts,
  output psm_pkg::cmd_t            cmd,
  output logic [VIDX_W-1:0]        issue_idx
);
  import psm_pkg::*;

  localparam logic [VIDX_W-1:0] LAST_VOICE = VIDX_W'(VOICE_COUNT - 1);

  state_t            state_r, state_nxt;
  logic [VIDX_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    issue_idx = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (opcode)
            OP_TICK: begin
              cmd.start = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_RUN;
            end
            OP_PRESS:   cmd.press       = 1'b1;
            OP_RELEASE: cmd.release_key = 1'b1;
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.issue = 1'b1;
        if (cnt_r == LAST_VOICE) begin
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_full) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* hw/rtl/psm_datapath.sv */
// ----------------------------------------------------------------------------
// psm_datapath
// Voice state, sine lookup, multiply-accumulate, fade and output register.
// ----------------------------------------------------------------------------
module psm_datapath #(
  parameter int VOICE_COUNT    = 13,
  parameter int SINE_ADDR_BITS = 10,
  parameter int PHASE_BITS     = 32,
  parameter int VIDX_W         = 4
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  psm_pkg::cmd_t                          cmd,
  input  logic [VIDX_W-1:0]                      issue_idx,
  input  logic [psm_pkg::VOICE_W-1:0]            key_voice,
  output psm_pkg::status_t                       sts,
  input  logic                                   cfg_wr_en,
  input  logic [psm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [psm_pkg::VOLUME_W-1:0]           cfg_data,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  output logic [psm_pkg::SAMPLE_W-1:0]           out_tdata
);
  import psm_pkg::*;

  localparam int SINE_DEPTH = 1 << SINE_ADDR_BITS;
  localparam int PROD_W     = VOLUME_W + SINE_W + 1;
  localparam int ACC_W      = PROD_W + VIDX_W;

  logic [FADE_W-1:0]         fade_r;
  logic [VOLUME_W-1:0]       base_r;
  logic [VOLUME_W-1:0]       vol_r   [VOICE_COUNT];
  logic [PHASE_BITS-1:0]     phase_r [VOICE_COUNT];
  logic [VOICE_COUNT-1:0]    held_r;
  logic signed [SINE_W-1:0]  sine_rom [SINE_DEPTH];

  logic                      va_r, vp_r;
  logic [VOLUME_W-1:0]       vol_a_r;
  logic                      held_a_r;
  logic [VIDX_W-1:0]         idx_a_r;
  logic signed [SINE_W-1:0]  sine_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic                      out_valid_r;
  logic [SAMPLE_W-1:0]       out_data_r;

  logic                      key_ok;
  logic [VIDX_W-1:0]         key_idx;
  logic [PHASE_BITS-1:0]     step_w;
  logic [SINE_ADDR_BITS-1:0] sine_addr;
  logic [VOLUME_W+FADE_W-1:0] fade_prod;
  logic signed [ACC_W-1:0]   shifted;
  logic                      sat_hi, sat_lo;
  logic [SAMPLE_W-1:0]       sample;

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
    localparam logic signed [SINE_W-1:0] ENTRY = sine_entry(g, SINE_ADDR_BITS);
    assign sine_rom[g] = ENTRY;
  end

  assign key_ok    = {1'b0, key_voice} < (VOICE_W + 1)'(VOICE_COUNT);
  assign key_idx   = key_voice[VIDX_W-1:0];
  assign step_w    = PHASE_BITS'(STEP32[4'(issue_idx)] >> (32 - PHASE_BITS));
  assign sine_addr = phase_r[issue_idx][PHASE_BITS-1 -: SINE_ADDR_BITS];
  assign fade_prod = vol_a_r * fade_r;

  assign shifted = acc_r >>> FRAC_SHIFT;
  assign sat_hi  = !shifted[ACC_W-1] && (|shifted[ACC_W-2:SAMPLE_W-1]);
  assign sat_lo  = shifted[ACC_W-1] && !(&shifted[ACC_W-2:SAMPLE_W-1]);
  always_comb begin
    if (sat_hi) begin
      sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (sat_lo) begin
      sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sample = shifted[SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_r <= FADE_RESET;
      base_r <= BASE_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_FADE: fade_r <= cfg_data[FADE_W-1:0];
        REG_BASE: base_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        vol_r[v]   <= '0;
        phase_r[v] <= '0;
      end
    end else begin
      if (cmd.press && key_ok) begin
        held_r[key_idx] <= 1'b1;
        vol_r[key_idx]  <= base_r;
      end
      if (cmd.release_key && key_ok) begin
        held_r[key_idx] <= 1'b0;
      end
      if (cmd.issue) begin
        phase_r[issue_idx] <= phase_r[issue_idx] + step_w;
      end
      if (va_r && !held_a_r && vol_a_r != '0) begin
        vol_r[idx_a_r] <= fade_prod[VOLUME_W+FADE_W-1:FADE_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vp_r <= 1'b0;
    end else begin
      va_r <= cmd.issue;
      vp_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    sine_r   <= sine_rom[sine_addr];
    vol_a_r  <= vol_r[issue_idx];
    held_a_r <= held_r[issue_idx];
    idx_a_r  <= issue_idx;
    prod_r   <= $signed({1'b0, vol_a_r}) * sine_r;
    if (cmd.start) begin
      acc_r <= '0;
    end else if (vp_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= sample;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign sts.pipe_busy = va_r | vp_r;
  assign sts.out_full  = out_valid_r & ~out_tready;

  a_emit_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !va_r && !vp_r)
    else $error("result emitted before the voice pipeline drained");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !out_valid_r || out_tready)
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !$past(out_valid_r) |-> $past(cmd.emit))
    else $error("result raised without an emit");

  a_no_key_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (va_r || vp_r) |-> !cmd.press && !cmd.release_key)
    else $error("key event during a tick");

endmodule
